>>> rtl/dbsw_pkg.sv
// Shared types, codes and helpers for the debounced button stopwatch.
// Used by dbsw_step and debounced_button_stopwatch; no dependencies.
package dbsw_pkg;

	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FINAL = 2'd1;
	localparam logic [1:0] PH_FIRST = 2'd2;
	localparam logic [1:0] PH_GAP   = 2'd3;

	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_INTERVAL = 3'd1;
	localparam logic [2:0] REG_SS_CHIRP = 3'd2;
	localparam logic [2:0] REG_RS_CHIRP = 3'd3;
	localparam logic [2:0] REG_RS_GAP   = 3'd4;

	localparam logic [7:0] DEF_DEBOUNCE = 8'd50;
	localparam logic [7:0] DEF_INTERVAL = 8'd30;
	localparam logic [7:0] DEF_SS_CHIRP = 8'd60;
	localparam logic [7:0] DEF_RS_CHIRP = 8'd15;
	localparam logic [7:0] DEF_RS_GAP   = 8'd120;

	localparam logic [7:0] SAT_MAX   = 8'd255;
	localparam logic [3:0] MS_LAST   = 4'd9;
	localparam logic [6:0] DIGIT_TOP = 7'd99;

	typedef struct packed {
		logic [7:0] debounce;
		logic [7:0] interval;
		logic [7:0] ss_chirp;
		logic [7:0] rs_chirp;
		logic [7:0] rs_gap;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] ms_unit;
		logic [6:0] hund;
		logic [6:0] secs;
		logic [7:0] since_refresh;
		logic       prev_level;
		logic [7:0] stable_ms;
		logic       press_taken;
		logic [6:0] shown_secs;
		logic [6:0] shown_hund;
		logic [7:0] chirp_left;
		logic [1:0] chirp_phase;
	} state_t;

	typedef struct packed {
		logic [1:0] run_mode;
		logic       buzzer_on;
		logic       show_now;
		logic [6:0] seconds_shown;
		logic [6:0] hundredths_shown;
	} result_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] left;
	} chirp_t;

	// Enter a chirp phase, skipping phases of zero length.
	function automatic chirp_t enter_phase(input logic [1:0] ph, input logic [7:0] rs_chirp,
		input logic [7:0] rs_gap);
		chirp_t c;
		c = '{phase: PH_IDLE, left: 8'd0};
		case (ph)
			PH_FIRST: begin
				if (rs_chirp != 8'd0)
					c = '{phase: PH_FIRST, left: rs_chirp};
				else if (rs_gap != 8'd0)
					c = '{phase: PH_GAP, left: rs_gap};
			end
			PH_GAP: begin
				if (rs_gap != 8'd0)
					c = '{phase: PH_GAP, left: rs_gap};
				else if (rs_chirp != 8'd0)
					c = '{phase: PH_FINAL, left: rs_chirp};
			end
			PH_FINAL: begin
				if (rs_chirp != 8'd0)
					c = '{phase: PH_FINAL, left: rs_chirp};
			end
			default: c = '{phase: PH_IDLE, left: 8'd0};
		endcase
		return c;
	endfunction

endpackage

>>> rtl/debounced_button_stopwatch.sv
// Debounced single-button stopwatch: top level with input and result registers.
// Depends on dbsw_pkg and dbsw_step.
// Flow: a beat accepted into s1 moves its result into s2 once s2 is empty or not stalled.
// Throughput: one beat per cycle while out_stall is low; the tick logic runs once per beat moving s1 -> s2.
// The s1 register takes a new beat while a stalled result waits in s2, provided s1 is empty.
// Reset: asynchronous; state clears (prev_level to 1), registers return to 50/30/60/15/120 ms.
module debounced_button_stopwatch (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       button_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] run_mode,
	output logic       buzzer_on,
	output logic       show_now,
	output logic [6:0] seconds_shown,
	output logic [6:0] hundredths_shown,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	dbsw_pkg::cfg_t    cfg_q;
	dbsw_pkg::state_t  state_q;
	dbsw_pkg::state_t  state_nxt;
	dbsw_pkg::result_t res_nxt;
	dbsw_pkg::result_t res_s2;
	logic valid_s1;
	logic level_s1;
	logic valid_s2;
	logic advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	dbsw_step u_step (
		.cur   (state_q),
		.level (level_s1),
		.cfg   (cfg_q),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{debounce: dbsw_pkg::DEF_DEBOUNCE, interval: dbsw_pkg::DEF_INTERVAL,
				ss_chirp: dbsw_pkg::DEF_SS_CHIRP, rs_chirp: dbsw_pkg::DEF_RS_CHIRP,
				rs_gap: dbsw_pkg::DEF_RS_GAP};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dbsw_pkg::REG_DEBOUNCE: cfg_q.debounce <= cfg_data;
				dbsw_pkg::REG_INTERVAL: cfg_q.interval <= cfg_data;
				dbsw_pkg::REG_SS_CHIRP: cfg_q.ss_chirp <= cfg_data;
				dbsw_pkg::REG_RS_CHIRP: cfg_q.rs_chirp <= cfg_data;
				dbsw_pkg::REG_RS_GAP:   cfg_q.rs_gap   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: dbsw_pkg::MODE_RESET, ms_unit: 4'd0, hund: 7'd0, secs: 7'd0,
				since_refresh: 8'd0, prev_level: 1'b1, stable_ms: 8'd0, press_taken: 1'b0,
				shown_secs: 7'd0, shown_hund: 7'd0, chirp_left: 8'd0,
				chirp_phase: dbsw_pkg::PH_IDLE};
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			level_s1 <= button_level;
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid        = valid_s2;
	assign run_mode         = res_s2.run_mode;
	assign buzzer_on        = res_s2.buzzer_on;
	assign show_now         = res_s2.show_now;
	assign seconds_shown    = res_s2.seconds_shown;
	assign hundredths_shown = res_s2.hundredths_shown;

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a beat");

	a_chirp_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.chirp_phase != dbsw_pkg::PH_IDLE |-> state_q.chirp_left != 8'd0)
		else $error("active chirp phase with zero length left");

	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.show_now && res_s2.run_mode == dbsw_pkg::MODE_RESET
		|-> res_s2.seconds_shown == 7'd0 && res_s2.hundredths_shown == 7'd0)
		else $error("reset refresh with nonzero digits");

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.seconds_shown <= dbsw_pkg::DIGIT_TOP
		&& res_s2.hundredths_shown <= dbsw_pkg::DIGIT_TOP)
		else $error("display digit out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

>>> rtl/dbsw_step.sv
// One millisecond tick of the stopwatch: next state and result from current state.
// Depends on dbsw_pkg.
module dbsw_step (
	input  dbsw_pkg::state_t  cur,
	input  logic              level,
	input  dbsw_pkg::cfg_t    cfg,
	output dbsw_pkg::state_t  nxt,
	output dbsw_pkg::result_t res
);

	always_comb begin
		dbsw_pkg::state_t s;
		dbsw_pkg::chirp_t c;
		logic fire;
		logic played;
		logic buzz;
		logic show;
		logic [1:0] next_ph;

		s      = cur;
		c      = '{phase: dbsw_pkg::PH_IDLE, left: 8'd0};
		played = 1'b0;
		buzz   = 1'b0;
		show   = 1'b0;
		fire   = 1'b0;
		next_ph = dbsw_pkg::PH_IDLE;

		// time base: ms digit, hundredths, seconds; wraps at 100 s
		if (s.mode == dbsw_pkg::MODE_RUN) begin
			if (s.ms_unit == dbsw_pkg::MS_LAST) begin
				s.ms_unit = 4'd0;
				if (s.hund == dbsw_pkg::DIGIT_TOP) begin
					s.hund = 7'd0;
					s.secs = (s.secs == dbsw_pkg::DIGIT_TOP) ? 7'd0 : s.secs + 7'd1;
				end else begin
					s.hund = s.hund + 7'd1;
				end
			end else begin
				s.ms_unit = s.ms_unit + 4'd1;
			end
		end
		if (s.since_refresh != dbsw_pkg::SAT_MAX)
			s.since_refresh = s.since_refresh + 8'd1;

		if (s.chirp_phase == dbsw_pkg::PH_IDLE) begin
			if (level != s.prev_level)
				s.stable_ms = 8'd0;
			else if (s.stable_ms != dbsw_pkg::SAT_MAX)
				s.stable_ms = s.stable_ms + 8'd1;
			s.prev_level = level;
			fire = (s.stable_ms > cfg.debounce) || (s.stable_ms == dbsw_pkg::SAT_MAX);
			if (fire) begin
				if (!level && !s.press_taken) begin
					s.press_taken = 1'b1;
					unique case (s.mode)
						dbsw_pkg::MODE_RESET: begin
							s.ms_unit = 4'd0;
							s.hund    = 7'd0;
							s.secs    = 7'd0;
							s.mode    = dbsw_pkg::MODE_RUN;
							s.chirp_phase = (cfg.ss_chirp != 8'd0) ? dbsw_pkg::PH_FINAL
								: dbsw_pkg::PH_IDLE;
							s.chirp_left  = cfg.ss_chirp;
						end
						dbsw_pkg::MODE_RUN: begin
							s.mode = dbsw_pkg::MODE_STOP;
							s.chirp_phase = (cfg.ss_chirp != 8'd0) ? dbsw_pkg::PH_FINAL
								: dbsw_pkg::PH_IDLE;
							s.chirp_left  = cfg.ss_chirp;
						end
						default: begin
							s.ms_unit    = 4'd0;
							s.hund       = 7'd0;
							s.secs       = 7'd0;
							s.mode       = dbsw_pkg::MODE_RESET;
							s.shown_secs = 7'd0;
							s.shown_hund = 7'd0;
							show         = 1'b1;
							c = dbsw_pkg::enter_phase(dbsw_pkg::PH_FIRST, cfg.rs_chirp,
								cfg.rs_gap);
							s.chirp_phase = c.phase;
							s.chirp_left  = c.left;
						end
					endcase
				end else if (level) begin
					s.press_taken = 1'b0;
				end
			end
		end else if (s.stable_ms != dbsw_pkg::SAT_MAX) begin
			s.stable_ms = s.stable_ms + 8'd1;
		end

		if (s.chirp_phase != dbsw_pkg::PH_IDLE) begin
			played = 1'b1;
			buzz = (s.chirp_phase == dbsw_pkg::PH_FINAL) || (s.chirp_phase == dbsw_pkg::PH_FIRST);
			if (s.chirp_left != 8'd0)
				s.chirp_left = s.chirp_left - 8'd1;
			if (s.chirp_left == 8'd0) begin
				unique case (s.chirp_phase)
					dbsw_pkg::PH_FIRST: next_ph = dbsw_pkg::PH_GAP;
					dbsw_pkg::PH_GAP:   next_ph = dbsw_pkg::PH_FINAL;
					default:            next_ph = dbsw_pkg::PH_IDLE;
				endcase
				c = dbsw_pkg::enter_phase(next_ph, cfg.rs_chirp, cfg.rs_gap);
				s.chirp_phase = c.phase;
				s.chirp_left  = c.left;
			end
		end

		if (s.mode == dbsw_pkg::MODE_RUN && !played && s.since_refresh >= cfg.interval) begin
			s.since_refresh = 8'd0;
			if (s.secs != s.shown_secs || s.hund != s.shown_hund) begin
				s.shown_secs = s.secs;
				s.shown_hund = s.hund;
				show = 1'b1;
			end
		end

		nxt = s;
		res.run_mode         = s.mode;
		res.buzzer_on        = buzz;
		res.show_now         = show;
		res.seconds_shown    = s.shown_secs;
		res.hundredths_shown = s.shown_hund;
	end

endmodule
